### rtl/blsp_pkg.sv
// ----------------------------------------------------------------------------
// blsp_pkg: shared types and constants of the line stepper
// Request, response and internal command layouts, widths and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package blsp_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_BITS = 12;                 // signed endpoint coordinate
   localparam int PIX_BITS   = COORD_BITS - 1;     // on-screen pixel coordinate
   localparam int LIMIT_BITS = 12;                 // screen limit registers
   localparam int DELTA_BITS = COORD_BITS + 2;     // twice a delta
   localparam int ERR_BITS   = COORD_BITS + 4;     // signed decision variable
   localparam int CMP_BITS   = ((PIX_BITS > LIMIT_BITS) ? PIX_BITS : LIMIT_BITS) + 1;
   localparam int COLOR_BITS = 32;

   // screen limits after reset
   localparam logic [LIMIT_BITS-1:0] WIDTH_RESET  = LIMIT_BITS'(640);
   localparam logic [LIMIT_BITS-1:0] HEIGHT_RESET = LIMIT_BITS'(480);

   // request opcodes
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   // configuration register indexes
   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                        op;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
      logic [COLOR_BITS-1:0]         line_color;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]           pixel_x;
      logic [PIX_BITS-1:0]           pixel_y;
      logic [COLOR_BITS-1:0]         pixel_color;
      logic                          has_pixel;
      logic                          finished;
   } rsp_type;

   // classified command handed from the front end to the stepper
   typedef struct packed {
      op_type                        op;
      logic                          steep;
      logic                          step_down;
      logic signed [COORD_BITS-1:0]  major_pos;
      logic signed [COORD_BITS-1:0]  minor_pos;
      logic signed [COORD_BITS-1:0]  major_end;
      logic signed [ERR_BITS-1:0]    error_term;
      logic signed [ERR_BITS-1:0]    diag_step;   // 2*dminor - 2*dmajor
      logic signed [ERR_BITS-1:0]    minor_step;  // 2*dminor
      logic [COLOR_BITS-1:0]         color;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/blsp_fifo.sv
// ----------------------------------------------------------------------------
// blsp_fifo: small synchronous queue
// Register-based FIFO with simultaneous push and pop, used between stages.
// ----------------------------------------------------------------------------
`default_nettype none

module blsp_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   output logic      full,
   input  wire T     wr_data,
   input  wire logic pop,
   output logic      empty,
   output T          rd_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   T                    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### rtl/blsp_front.sv
// ----------------------------------------------------------------------------
// blsp_front: request intake and line setup
// Two-stage pipeline: deltas and magnitudes, then octant choice, endpoint
// ordering and initial decision variable. Emits classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module blsp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire blsp_pkg::req_type req_data,
   output logic                  cmd_push,
   input  wire logic             cmd_full,
   output blsp_pkg::cmd_type     cmd_data
);

   import blsp_pkg::*;

   typedef struct packed {
      op_type                       op;
      logic signed [COORD_BITS-1:0] x0;
      logic signed [COORD_BITS-1:0] y0;
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic [COORD_BITS-1:0]        adx;
      logic [COORD_BITS-1:0]        ady;
      logic                         x_lt;   // x1 < x0
      logic                         x_gt;   // x1 > x0
      logic                         y_lt;
      logic                         y_gt;
      logic [COLOR_BITS-1:0]        color;
   } delta_type;

   logic      s1_valid_ff, s1_valid_in;
   logic      s2_valid_ff, s2_valid_in;
   delta_type s1_ff, s1_in;
   cmd_type   s2_ff, s2_in;
   logic      s1_adv, s2_adv;

   // stall chain
   assign s2_adv   = !s2_valid_ff || !cmd_full;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign req_full = !s1_adv;
   assign cmd_push = s2_valid_ff;
   assign cmd_data = s2_ff;

   // stage 1: signed deltas as magnitude plus direction
   always_comb begin
      s1_in.op    = req_data.op;
      s1_in.x0    = req_data.start_x;
      s1_in.y0    = req_data.start_y;
      s1_in.x1    = req_data.end_x;
      s1_in.y1    = req_data.end_y;
      s1_in.x_lt  = req_data.end_x < req_data.start_x;
      s1_in.x_gt  = req_data.end_x > req_data.start_x;
      s1_in.y_lt  = req_data.end_y < req_data.start_y;
      s1_in.y_gt  = req_data.end_y > req_data.start_y;
      s1_in.adx   = s1_in.x_lt ? COORD_BITS'(req_data.start_x - req_data.end_x)
                               : COORD_BITS'(req_data.end_x - req_data.start_x);
      s1_in.ady   = s1_in.y_lt ? COORD_BITS'(req_data.start_y - req_data.end_y)
                               : COORD_BITS'(req_data.end_y - req_data.start_y);
      s1_in.color = req_data.line_color;
   end

   // stage 2: octant, ordering along the major axis, decision variable
   always_comb begin
      logic                       steep;
      logic                       swap;
      logic [COORD_BITS-1:0]      dmaj;
      logic [COORD_BITS-1:0]      dmin;
      logic signed [ERR_BITS-1:0] dmaj_s;
      logic signed [ERR_BITS-1:0] tmin_s;
      logic signed [ERR_BITS-1:0] tmaj_s;

      steep = !(s1_ff.ady < s1_ff.adx);
      swap  = steep ? s1_ff.y_lt : s1_ff.x_lt;
      dmaj  = steep ? s1_ff.ady : s1_ff.adx;
      dmin  = steep ? s1_ff.adx : s1_ff.ady;

      dmaj_s = ERR_BITS'(dmaj);
      tmaj_s = ERR_BITS'({dmaj, 1'b0});
      tmin_s = ERR_BITS'({dmin, 1'b0});

      s2_in.op    = s1_ff.op;
      s2_in.steep = steep;
      if (steep) begin
         s2_in.step_down = swap ? s1_ff.x_gt : s1_ff.x_lt;
         s2_in.major_pos = swap ? s1_ff.y1 : s1_ff.y0;
         s2_in.minor_pos = swap ? s1_ff.x1 : s1_ff.x0;
         s2_in.major_end = swap ? s1_ff.y0 : s1_ff.y1;
      end else begin
         s2_in.step_down = swap ? s1_ff.y_gt : s1_ff.y_lt;
         s2_in.major_pos = swap ? s1_ff.x1 : s1_ff.x0;
         s2_in.minor_pos = swap ? s1_ff.y1 : s1_ff.y0;
         s2_in.major_end = swap ? s1_ff.x0 : s1_ff.x1;
      end
      s2_in.error_term = tmin_s - dmaj_s;
      s2_in.diag_step  = tmin_s - tmaj_s;
      s2_in.minor_step = tmin_s;
      s2_in.color      = s1_ff.color;
   end

   // valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s1_valid_in = req_push;
      end
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
   end

endmodule

`default_nettype wire

### rtl/blsp_back.sv
// ----------------------------------------------------------------------------
// blsp_back: line stepping engine
// Holds the active line and screen limits, runs one Bresenham step per
// step command and hands pixels or end markers to the response queue.
// ----------------------------------------------------------------------------
`default_nettype none

module blsp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire blsp_pkg::csr_index_type       csr_index,
   input  wire logic [blsp_pkg::LIMIT_BITS-1:0] csr_wdata,
   input  wire logic                          cmd_empty,
   output logic                               cmd_pop,
   input  wire blsp_pkg::cmd_type             cmd_data,
   input  wire logic                          out_full,
   output logic                               out_push,
   output blsp_pkg::rsp_type                  out_data
);

   import blsp_pkg::*;

   logic [LIMIT_BITS-1:0]        width_ff, width_in;
   logic [LIMIT_BITS-1:0]        height_ff, height_in;
   logic                         active_ff, active_in;
   logic                         steep_ff, steep_in;
   logic                         step_down_ff, step_down_in;
   logic signed [COORD_BITS-1:0] major_ff, major_in;
   logic signed [COORD_BITS-1:0] minor_ff, minor_in;
   logic signed [COORD_BITS-1:0] end_ff, end_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic signed [ERR_BITS-1:0]   diag_ff, diag_in;
   logic signed [ERR_BITS-1:0]   tmin_ff, tmin_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;

   logic signed [COORD_BITS-1:0] px, py;
   logic [CMP_BITS-1:0]          px_u, py_u;
   logic                         done;
   logic                         is_step;

   assign csr_ready = 1'b1;
   assign cmd_pop   = !cmd_empty && !out_full;
   assign is_step   = (cmd_data.op == OP_STEP);
   assign out_push  = cmd_pop && is_step && active_ff;

   // current pixel and termination test
   always_comb begin
      px   = steep_ff ? minor_ff : major_ff;
      py   = steep_ff ? major_ff : minor_ff;
      px_u = CMP_BITS'(px[PIX_BITS-1:0]);
      py_u = CMP_BITS'(py[PIX_BITS-1:0]);
      done = !(major_ff < end_ff)
             || px[COORD_BITS-1] || (px_u >= CMP_BITS'(width_ff))
             || py[COORD_BITS-1] || (py_u >= CMP_BITS'(height_ff));
   end

   // response item
   always_comb begin
      if (done) begin
         out_data = '0;
         out_data.finished = 1'b1;
      end else begin
         out_data.pixel_x     = px[PIX_BITS-1:0];
         out_data.pixel_y     = py[PIX_BITS-1:0];
         out_data.pixel_color = color_ff;
         out_data.has_pixel   = 1'b1;
         out_data.finished    = 1'b0;
      end
   end

   // line state: load replaces, step advances
   always_comb begin
      active_in    = active_ff;
      steep_in     = steep_ff;
      step_down_in = step_down_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      end_in       = end_ff;
      err_in       = err_ff;
      diag_in      = diag_ff;
      tmin_in      = tmin_ff;
      color_in     = color_ff;
      if (cmd_pop) begin
         if (!is_step) begin
            active_in    = 1'b1;
            steep_in     = cmd_data.steep;
            step_down_in = cmd_data.step_down;
            major_in     = cmd_data.major_pos;
            minor_in     = cmd_data.minor_pos;
            end_in       = cmd_data.major_end;
            err_in       = cmd_data.error_term;
            diag_in      = cmd_data.diag_step;
            tmin_in      = cmd_data.minor_step;
            color_in     = cmd_data.color;
         end else if (active_ff) begin
            if (done) begin
               active_in = 1'b0;
            end else begin
               major_in = major_ff + COORD_BITS'(1);
               if (err_ff > 0) begin
                  minor_in = step_down_ff ? minor_ff - COORD_BITS'(1)
                                          : minor_ff + COORD_BITS'(1);
                  err_in   = err_ff + diag_ff;
               end else begin
                  err_in   = err_ff + tmin_ff;
               end
            end
         end
      end
   end

   // screen limit registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         active_ff <= active_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff     <= steep_in;
      step_down_ff <= step_down_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      end_ff       <= end_in;
      err_ff       <= err_in;
      diag_ff      <= diag_in;
      tmin_ff      <= tmin_in;
      color_ff     <= color_in;
   end

endmodule

`default_nettype wire

### rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper: integer line rasterizer
// Load a line, then pull one logical pixel or an end marker per step request.
// ----------------------------------------------------------------------------
// A load request (op = load) sets up a half-open line from start to end with
// its color and gives no response; each later step request gives one response:
// a pixel, or an end marker (finished) once the far endpoint is reached or the
// first pixel falls off the screen. A step while no line is active gives
// nothing. Requests are taken one per clock while req_full is low; the front
// end does the setup in two pipeline stages, a command queue of CMD_DEPTH
// entries decouples it from the stepper, and the stepper does one error-term
// add and bounds compare per clock unless the command queue is empty or the
// response queue full. The user must write screen limits through csr_ only
// while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper #(
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire blsp_pkg::req_type               req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output blsp_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire blsp_pkg::csr_index_type         csr_index,
   input  wire logic [blsp_pkg::LIMIT_BITS-1:0] csr_wdata
);

   import blsp_pkg::*;

   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_in_data, cmd_out_data;
   logic    out_push, out_full;
   rsp_type out_data;

   // request intake and setup
   blsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_in_data)
   );

   // command queue between setup and stepping
   blsp_fifo #(
      .T     (cmd_type),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .full    (cmd_full),
      .wr_data (cmd_in_data),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_out_data)
   );

   // stepping engine
   blsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out_data),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // response queue
   blsp_fifo #(
      .T     (rsp_type),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .full    (out_full),
      .wr_data (out_data),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/blsp_checker.sv
// ----------------------------------------------------------------------------
// blsp_checker: port-level checks for the line stepper
// Watches the response side for malformed or unstable responses.
// ----------------------------------------------------------------------------
`default_nettype none

module blsp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire blsp_pkg::rsp_type rsp_data
);

   import blsp_pkg::*;

   // queue comes out of reset empty
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // a response is either a pixel or an end marker, never both
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.has_pixel && rsp_data.finished))
      else $error("response marks both pixel and finished");

   // every response is at least one of the two kinds
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.has_pixel || rsp_data.finished))
      else $error("response carries neither pixel nor end marker");

   // end markers carry a zero payload
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.finished) |->
         (rsp_data.pixel_x == '0) && (rsp_data.pixel_y == '0)
         && (rsp_data.pixel_color == '0))
      else $error("end marker with nonzero payload");

   // an unread response stays put
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("pending response changed before pop");

endmodule

bind bresenham_line_stepper blsp_checker u_checker (.*);

`default_nettype wire

### verif/bresenham_line_stepper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_tb: self-checking bench for the line stepper
// Drives load and step requests through the request queue port and predicts
// every pixel and end marker with an in-bench line rasterizer. A directed list
// comes first, then random lines under several screen sizes, with random
// stalls on both sides.
// ----------------------------------------------------------------------------

module bresenham_line_stepper_tb;

   import blsp_pkg::*;

   localparam int COORD_MAX     = 2**(COORD_BITS-1) - 1;
   localparam int COORD_MIN     = -(2**(COORD_BITS-1));
   localparam int SETTLE_CYCLES = 16;     // pipeline plus command queue, with margin
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 190;

   localparam rsp_type END_MARKER = '{pixel_x: '0, pixel_y: '0, pixel_color: '0,
                                      has_pixel: 1'b0, finished: 1'b1};

   // how a directed row gets its expected response
   typedef enum {
      CHECK_PREDICT,
      CHECK_NONE,
      CHECK_END
   } row_check_type;

   typedef struct {
      row_check_type chk;
      req_type       item;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   csr_index_type csr_index;
   logic [LIMIT_BITS-1:0] csr_wdata;

   // screen sizes per random phase; the last one runs without stalls
   int phase_w [PHASE_COUNT] = '{0, 640, 1, 2048, 4095, 17, 2048, 640};
   int phase_h [PHASE_COUNT] = '{480, 0, 1, 2048, 4095, 2048, 9, 480};

   rsp_type      pending_pixels [$];
   stim_row_type dir_rows [$];
   rsp_type      want;
   int           mismatch_count = 0;
   int           rsp_count = 0;
   bit           steady = 1'b0;

   // rasterizer state mirror
   int          scr_width  = 640;
   int          scr_height = 480;
   bit          ln_active  = 1'b0;
   bit          ln_steep   = 1'b0;
   bit          ln_down    = 1'b0;
   int          ln_major   = 0;
   int          ln_minor   = 0;
   int          ln_major_end = 0;
   int          ln_err     = 0;
   int          ln_twice_maj = 0;
   int          ln_twice_min = 0;
   logic [COLOR_BITS-1:0] ln_color = '0;

   bresenham_line_stepper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR: %s", msg);
   endtask

   // advance the mirrored line by one request; got is set when a response follows
   function automatic void rasterize_request(input req_type item, output bit got,
                                             output rsp_type res);
      int x0, y0, x1, y1, a0, b0, a1, b1, t, dmaj, dmin, px, py;
      bit done;
      got = 1'b0;
      res = '0;
      if (item.op == OP_LOAD) begin
         x0 = $signed(item.start_x);
         y0 = $signed(item.start_y);
         x1 = $signed(item.end_x);
         y1 = $signed(item.end_y);
         dmaj = x1 - x0;
         if (dmaj < 0) dmaj = -dmaj;
         dmin = y1 - y0;
         if (dmin < 0) dmin = -dmin;
         // equal slopes fall on the steep side
         ln_steep = (dmin >= dmaj);
         if (ln_steep) begin
            a0 = y0; b0 = x0; a1 = y1; b1 = x1;
         end else begin
            a0 = x0; b0 = y0; a1 = x1; b1 = y1;
         end
         // walk the major axis upward
         if (a0 > a1) begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
         end
         dmaj = a1 - a0;
         dmin = b1 - b0;
         ln_down = (dmin < 0);
         if (dmin < 0) dmin = -dmin;
         ln_major     = a0;
         ln_minor     = b0;
         ln_major_end = a1;
         ln_twice_maj = 2 * dmaj;
         ln_twice_min = 2 * dmin;
         ln_err       = 2 * dmin - dmaj;
         ln_color     = item.line_color;
         ln_active    = 1'b1;
      end else if (ln_active) begin
         got = 1'b1;
         px = ln_steep ? ln_minor : ln_major;
         py = ln_steep ? ln_major : ln_minor;
         // far endpoint reached, or first pixel off the screen
         done = (ln_major >= ln_major_end) || px < 0 || px >= scr_width ||
                py < 0 || py >= scr_height;
         if (done) begin
            ln_active = 1'b0;
            res = END_MARKER;
         end else begin
            res.pixel_x     = px[PIX_BITS-1:0];
            res.pixel_y     = py[PIX_BITS-1:0];
            res.pixel_color = ln_color;
            res.has_pixel   = 1'b1;
            if (ln_err > 0) begin
               ln_minor = ln_down ? ln_minor - 1 : ln_minor + 1;
               ln_err   = ln_err - ln_twice_maj;
            end
            ln_err   = ln_err + ln_twice_min;
            ln_major = ln_major + 1;
         end
      end
   endfunction

   function automatic req_type random_req();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   // region 0: anywhere; 1 to 6: near the origin; others: near the far screen edge
   function automatic logic signed [COORD_BITS-1:0] pick_coord(input int region,
                                                                input int limit);
      int v;
      int far;
      far = (limit > COORD_MAX + 1) ? COORD_MAX + 1 : limit;
      case (region) inside
         0:       v = int'($urandom_range(0, 2*COORD_MAX + 1)) + COORD_MIN;
         [1:6]:   v = int'($urandom_range(0, 44)) - 3;
         default: v = far - 40 + int'($urandom_range(0, 43));
      endcase
      if (v > COORD_MAX) v = COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   function automatic req_type line_load();
      req_type item;
      int region;
      item = random_req();
      item.op = OP_LOAD;
      region = $urandom_range(0, 9);
      item.start_x = pick_coord(region, scr_width);
      item.start_y = pick_coord(region, scr_height);
      item.end_x   = pick_coord(region, scr_width);
      item.end_y   = pick_coord(region, scr_height);
      return item;
   endfunction

   task automatic add_row(input row_check_type chk, input op_type op, input int sx,
                          input int sy, input int ex, input int ey,
                          input logic [COLOR_BITS-1:0] color);
      stim_row_type row;
      row.chk             = chk;
      row.item.op         = op;
      row.item.start_x    = COORD_BITS'(sx);
      row.item.start_y    = COORD_BITS'(sy);
      row.item.end_x      = COORD_BITS'(ex);
      row.item.end_y      = COORD_BITS'(ey);
      row.item.line_color = color;
      dir_rows.push_back(row);
   endtask

   // push one request, predict at acceptance; counted is low for ignored steps
   task automatic send_item(input req_type item, input row_check_type chk,
                            output bit counted);
      bit got;
      rsp_type res;
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      counted = (item.op == OP_LOAD) || ln_active;
      rasterize_request(item, got, res);
      case (chk)
         CHECK_PREDICT: if (got) pending_pixels.push_back(res);
         CHECK_END:     pending_pixels.push_back(END_MARKER);
         default:       ;
      endcase
   endtask

   // random sender gap
   task automatic pace(input bit quiet);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // stop sending until all responses are in and the pipeline has emptied
   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_screen(input int w, input int h);
      csr_index <= CSR_WIDTH;
      csr_wdata <= LIMIT_BITS'(w);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scr_width = w;
      csr_index <= CSR_HEIGHT;
      csr_wdata <= LIMIT_BITS'(h);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      scr_height = h;
      csr_valid <= 1'b0;
   endtask

   // mostly whole lines with random content, some cut short, some noise
   task automatic run_phase(input int quota);
      int sent, cap, n;
      bit counted, quiet;
      req_type item;
      sent = 0;
      while (sent < quota) begin
         quiet = steady || ($urandom_range(0, 3) == 0);
         if (!steady && $urandom_range(0, 49) == 0) wait_for_drain();
         if ($urandom_range(0, 9) == 0) begin
            pace(quiet);
            send_item(random_req(), CHECK_PREDICT, counted);
            sent += counted;
         end else begin
            pace(quiet);
            send_item(line_load(), CHECK_PREDICT, counted);
            sent += counted;
            cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 60;
            n = 0;
            while (ln_active && n < cap) begin
               item = random_req();
               item.op = OP_STEP;
               pace(quiet);
               send_item(item, CHECK_PREDICT, counted);
               sent += counted;
               n++;
            end
            // stray step after the line, usually ignored
            if ($urandom_range(0, 3) == 0) begin
               item = random_req();
               item.op = OP_STEP;
               pace(quiet);
               send_item(item, CHECK_PREDICT, counted);
               sent += counted;
            end
         end
      end
   endtask

   // response side: random pop bursts, steady at the end
   initial begin
      forever begin
         if (steady) begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // response check, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      if (reset == 1'b0 && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("response %0d with nothing pending: %h",
                                    rsp_count, rsp_data));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x)
               flag_mismatch($sformatf("response %0d pixel_x got %0d want %0d",
                                       rsp_count, rsp_data.pixel_x, want.pixel_x));
            if (rsp_data.pixel_y !== want.pixel_y)
               flag_mismatch($sformatf("response %0d pixel_y got %0d want %0d",
                                       rsp_count, rsp_data.pixel_y, want.pixel_y));
            if (rsp_data.pixel_color !== want.pixel_color)
               flag_mismatch($sformatf("response %0d pixel_color got %h want %h",
                                       rsp_count, rsp_data.pixel_color,
                                       want.pixel_color));
            if (rsp_data.has_pixel !== want.has_pixel)
               flag_mismatch($sformatf("response %0d has_pixel got %b want %b",
                                       rsp_count, rsp_data.has_pixel, want.has_pixel));
            if (rsp_data.finished !== want.finished)
               flag_mismatch($sformatf("response %0d finished got %b want %b",
                                       rsp_count, rsp_data.finished, want.finished));
         end
         rsp_count++;
      end
   end

   initial begin : stimulus
      bit counted;
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_wdata <= '0;

      // directed list, reset screen of 640 x 480
      add_row(CHECK_NONE,    OP_STEP, 0, 0, 0, 0, 32'h0);            // step while idle
      add_row(CHECK_NONE,    OP_LOAD, 0, 0, 0, 0, 32'h0);            // zero-length line
      add_row(CHECK_END,     OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_LOAD, 0, 0, 3, 1, 32'hFFFF_FFFF);    // shallow
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);            // far end
      add_row(CHECK_NONE,    OP_LOAD, 5, 5, 3, -1, 32'h1234_5678);   // steep, swapped
      add_row(CHECK_END,     OP_STEP, 0, 0, 0, 0, 32'h0);            // starts above top
      add_row(CHECK_NONE,    OP_LOAD, 2, 2, 0, 4, 32'hA5A5_A5A5);    // diagonal
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_LOAD, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
              32'h5A5A_5A5A);                                        // replaces line
      add_row(CHECK_END,     OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_LOAD, 637, 10, 645, 10, 32'hC0FF_EE00); // right edge
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_LOAD, 639, 479, 640, 480, 32'h0F0F_0F0F); // corner
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_PREDICT, OP_STEP, 0, 0, 0, 0, 32'h0);
      add_row(CHECK_NONE,    OP_LOAD, COORD_MAX, 0, COORD_MIN, 0, 32'h8000_0001);
      add_row(CHECK_END,     OP_STEP, 0, 0, 0, 0, 32'h0);            // starts left of screen

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         pace(1'b0);
         send_item(dir_rows[i].item, dir_rows[i].chk, counted);
      end

      // random phases, screen rewritten between them
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_drain();
         if (p == PHASE_COUNT - 1) steady = 1'b1;
         set_screen(phase_w[p], phase_h[p]);
         run_phase(PHASE_ITEMS);
      end

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
